// ===== hw/rtl/mtep_pkg.sv =====
package mtep_pkg;

	localparam int VLQ_WIDTH = 28;
	localparam int DELTA_W   = 28;
	localparam int TEMPO_W   = 24;
	localparam int NOTE_W    = 7;
	localparam int CHAN_W    = 4;
	localparam int SUM_W     = ((VLQ_WIDTH > DELTA_W) ? VLQ_WIDTH : DELTA_W) + 1;

	localparam logic [DELTA_W-1:0] DELTA_MAX   = '1;
	localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd500000;

	localparam logic [7:0] ST_META       = 8'hFF;
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [3:0] KIND_SYSTEM   = 4'hF;
	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_PROGRAM  = 4'hC;
	localparam logic [3:0] KIND_PRESSURE = 4'hD;

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA1,
		PH_NOTE_VEL,
		PH_SKIP,
		PH_META_TYPE,
		PH_META_LEN,
		PH_META_DATA,
		PH_SYSEX_LEN
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [DELTA_W-1:0] delta_ticks;
		logic [NOTE_W-1:0]  note_number;
		logic [NOTE_W-1:0]  velocity;
		logic               is_note_off;
		logic [CHAN_W-1:0]  channel;
		logic [TEMPO_W-1:0] current_tempo;
	} result_t;

	// shift one 7-bit group into a vlq value, saturating at all ones
	function automatic logic [VLQ_WIDTH-1:0] vlq_shift(logic [VLQ_WIDTH-1:0] acc,
		logic [6:0] grp);
		logic [VLQ_WIDTH-1:0] res;
		if (|acc[VLQ_WIDTH-1 -: 7]) begin
			res = '1;
		end else begin
			res = {acc[VLQ_WIDTH-8:0], grp};
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/mtep_in_reg.sv =====
module mtep_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mtep_pkg::item_t in_item,
	input  logic            take,
	output logic            vld_s1,
	output mtep_pkg::item_t item_s1
);

	assign in_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/mtep_parser.sv =====
module mtep_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  mtep_pkg::item_t   item,
	output logic              res_vld,
	output mtep_pkg::result_t res
);

	localparam logic [mtep_pkg::SUM_W-1:0] SUM_MAX =
		mtep_pkg::SUM_W'(mtep_pkg::DELTA_MAX);

	mtep_pkg::phase_t                     phase_q, phase_n;
	logic [mtep_pkg::VLQ_WIDTH-1:0]       vlq_q, vlq_n;
	logic [mtep_pkg::DELTA_W-1:0]         pend_q, pend_n;
	logic [7:0]                           rs_q, rs_n;
	logic [mtep_pkg::NOTE_W-1:0]          first_q, first_n;
	logic [7:0]                           meta_q, meta_n;
	logic [mtep_pkg::VLQ_WIDTH-1:0]       left_q, left_n;
	logic [mtep_pkg::TEMPO_W-1:0]         tacc_q, tacc_n;
	logic [mtep_pkg::TEMPO_W-1:0]         tempo_q, tempo_n;

	logic [7:0]                           b;
	logic [mtep_pkg::VLQ_WIDTH-1:0]       vlq_sh;
	logic [mtep_pkg::VLQ_WIDTH-1:0]       left_dec;
	logic [mtep_pkg::SUM_W-1:0]           sum;
	logic                                 do_first;
	logic                                 off;

	assign b        = item.in_byte;
	assign vlq_sh   = mtep_pkg::vlq_shift(vlq_q, b[6:0]);
	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;
	assign sum      = mtep_pkg::SUM_W'(pend_q) + mtep_pkg::SUM_W'(vlq_sh);
	assign off      = (rs_q[7:4] == mtep_pkg::KIND_NOTE_OFF);

	always_comb begin
		phase_n  = phase_q;
		vlq_n    = vlq_q;
		pend_n   = pend_q;
		rs_n     = rs_q;
		first_n  = first_q;
		meta_n   = meta_q;
		left_n   = left_q;
		tacc_n   = tacc_q;
		tempo_n  = tempo_q;
		do_first = 1'b0;
		res_vld  = 1'b0;

		res.delta_ticks   = pend_q;
		res.note_number   = first_q;
		res.velocity      = off ? '0 : b[6:0];
		res.is_note_off   = off;
		res.channel       = rs_q[3:0];
		res.current_tempo = tempo_q;

		unique case (phase_q)
			mtep_pkg::PH_STATUS: begin
				if (!b[7]) begin
					if (rs_q == '0) begin
						phase_n = mtep_pkg::PH_DELTA;
					end else begin
						do_first = 1'b1;
					end
				end else if (b[7:4] != mtep_pkg::KIND_SYSTEM) begin
					rs_n    = b;
					phase_n = mtep_pkg::PH_DATA1;
				end else if (b == mtep_pkg::ST_META) begin
					rs_n    = '0;
					phase_n = mtep_pkg::PH_META_TYPE;
				end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
					rs_n    = '0;
					vlq_n   = '0;
					phase_n = mtep_pkg::PH_SYSEX_LEN;
				end else begin
					rs_n    = '0;
					phase_n = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_DATA1: begin
				do_first = 1'b1;
			end
			mtep_pkg::PH_NOTE_VEL: begin
				res_vld = 1'b1;
				pend_n  = '0;
				phase_n = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_SKIP: begin
				left_n = left_dec;
				if (left_dec == '0) begin
					phase_n = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_META_TYPE: begin
				meta_n  = b;
				vlq_n   = '0;
				phase_n = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				vlq_n = vlq_sh;
				if (!b[7]) begin
					left_n  = vlq_sh;
					vlq_n   = '0;
					tacc_n  = '0;
					phase_n = (vlq_sh == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_META_DATA;
				end
			end
			mtep_pkg::PH_META_DATA: begin
				// tempo bytes arrive big-endian, only the low 24 bits survive
				if (meta_q == mtep_pkg::META_TEMPO) begin
					tacc_n = {tacc_q[mtep_pkg::TEMPO_W-9:0], b};
				end
				left_n = left_dec;
				if (left_dec == '0) begin
					if (meta_q == mtep_pkg::META_TEMPO) begin
						tempo_n = tacc_n;
					end
					vlq_n   = '0;
					phase_n = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_SYSEX_LEN: begin
				vlq_n = vlq_sh;
				if (!b[7]) begin
					left_n  = vlq_sh;
					vlq_n   = '0;
					phase_n = (vlq_sh == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
				end
			end
			default: begin
				vlq_n = vlq_sh;
				if (!b[7]) begin
					pend_n  = (sum > SUM_MAX) ? mtep_pkg::DELTA_MAX
						: sum[mtep_pkg::DELTA_W-1:0];
					vlq_n   = '0;
					phase_n = mtep_pkg::PH_STATUS;
				end
			end
		endcase

		// first data byte of a channel event, explicit or under running status
		if (do_first) begin
			priority if (rs_q[7:4] == mtep_pkg::KIND_NOTE_OFF
				|| rs_q[7:4] == mtep_pkg::KIND_NOTE_ON) begin
				first_n = b[6:0];
				phase_n = mtep_pkg::PH_NOTE_VEL;
			end else if (rs_q[7:4] == mtep_pkg::KIND_PROGRAM
				|| rs_q[7:4] == mtep_pkg::KIND_PRESSURE) begin
				phase_n = mtep_pkg::PH_DELTA;
			end else begin
				left_n  = mtep_pkg::VLQ_WIDTH'(1);
				phase_n = mtep_pkg::PH_SKIP;
			end
		end

		// end of track: everything but the tempo goes back to reset
		if (item.last_byte) begin
			phase_n = mtep_pkg::PH_DELTA;
			vlq_n   = '0;
			pend_n  = '0;
			rs_n    = '0;
			first_n = '0;
			meta_n  = '0;
			left_n  = '0;
			tacc_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mtep_pkg::PH_DELTA;
			vlq_q   <= '0;
			pend_q  <= '0;
			rs_q    <= '0;
			first_q <= '0;
			meta_q  <= '0;
			left_q  <= '0;
			tacc_q  <= '0;
			tempo_q <= mtep_pkg::TEMPO_RESET;
		end else if (fire) begin
			phase_q <= phase_n;
			vlq_q   <= vlq_n;
			pend_q  <= pend_n;
			rs_q    <= rs_n;
			first_q <= first_n;
			meta_q  <= meta_n;
			left_q  <= left_n;
			tacc_q  <= tacc_n;
			tempo_q <= tempo_n;
		end
	end

endmodule

// ===== hw/rtl/mtep_out_reg.sv =====
module mtep_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              res_vld,
	input  mtep_pkg::result_t res,
	output logic              out_valid_q,
	input  logic              out_ready,
	output mtep_pkg::result_t out_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res_vld;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_vld) begin
			out_q <= res;
		end
	end

endmodule

// ===== hw/rtl/midi_track_event_parser_top.sv =====
// channel   dir  tdata fields (low bit up)                      tuser / tlast
// s_axis    in   in_byte[7:0]                                   tlast = last_byte
// m_axis    out  delta_ticks[27:0] note_number[34:28]           tuser = is_note_off
//                velocity[41:35] channel[45:42]
//                current_tempo[69:46], zero pad [71:70]
//
// one byte per cycle sustained while the result word is not stalled; a byte passes an
// input register, then the parser state update and the result register, so a note word
// is registered from its velocity byte as that byte leaves the input register.
// arst_n clears the parse state and sets the tempo to 500000 us per quarter note.
// a stalled result word only blocks the parser; the input register still takes
// one more byte, then s_axis_tready drops until the result is taken.
module midi_track_event_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // delta_ticks, note_number, velocity, channel, current_tempo
	output logic        m_axis_tuser   // is_note_off
);

	mtep_pkg::item_t   in_item;
	mtep_pkg::item_t   item_s1;
	mtep_pkg::result_t res;
	mtep_pkg::result_t out_q;
	logic              vld_s1;
	logic              fire;
	logic              res_vld;

	assign in_item.in_byte   = s_axis_tdata;
	assign in_item.last_byte = s_axis_tlast;

	// parser advances whenever the input register holds a byte and the result slot is free or being drained
	assign fire = vld_s1 && (!m_axis_tvalid || m_axis_tready);

	mtep_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (fire),
		.vld_s1   (vld_s1),
		.item_s1  (item_s1)
	);

	mtep_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	mtep_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.res_vld     (res_vld),
		.res         (res),
		.out_valid_q (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_q       (out_q)
	);

	assign m_axis_tdata = {2'b00, out_q.current_tempo, out_q.channel, out_q.velocity,
		out_q.note_number, out_q.delta_ticks};
	assign m_axis_tuser = out_q.is_note_off;

endmodule

// ===== tb/tb_midi_track_event_parser_top.sv =====
`timescale 1ns / 100ps

module tb_midi_track_event_parser_top;

	typedef struct packed {
		logic [7:0]        b;
		logic              lst;
		logic              typed;
		mtep_pkg::result_t want;
	} dir_row_t;

	localparam mtep_pkg::result_t NO_NOTE = '0;
	localparam int                DIR_ROWS = 27;
	localparam int                PHASE_ITEMS = 250;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tuser;

	int                errs;
	int                items_sent;
	int unsigned       idle_pct;
	int unsigned       stall_pct;
	mtep_pkg::result_t notes_due[$];
	logic [7:0]        ev_bytes[$];
	dir_row_t          dir_tab [0:DIR_ROWS-1];

	// parser state kept by the testbench
	mtep_pkg::phase_t                 parse_phase;
	logic [mtep_pkg::VLQ_WIDTH-1:0]   vlq_val;
	logic [mtep_pkg::DELTA_W-1:0]     ticks_pending;
	logic [7:0]                       run_status;
	logic [mtep_pkg::NOTE_W-1:0]      note_key;
	logic [7:0]                       meta_type;
	logic [mtep_pkg::VLQ_WIDTH-1:0]   skip_left;
	logic [mtep_pkg::TEMPO_W-1:0]     tempo_us;

	midi_track_event_parser_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [mtep_pkg::VLQ_WIDTH-1:0] vlq_push(
		logic [mtep_pkg::VLQ_WIDTH-1:0] v, logic [7:0] b);
		if ((v >> (mtep_pkg::VLQ_WIDTH - 7)) != 0)
			return '1;
		return (v << 7) | mtep_pkg::VLQ_WIDTH'(b[6:0]);
	endfunction

	task automatic clear_parse_state();
		parse_phase   = mtep_pkg::PH_DELTA;
		vlq_val       = '0;
		ticks_pending = '0;
		run_status    = '0;
		note_key      = '0;
		meta_type     = '0;
		skip_left     = '0;
	endtask

	task automatic take_first_data(input logic [7:0] b);
		logic [3:0] kind;
		kind = run_status[7:4];
		if (kind == mtep_pkg::KIND_NOTE_OFF || kind == mtep_pkg::KIND_NOTE_ON) begin
			note_key    = b[6:0];
			parse_phase = mtep_pkg::PH_NOTE_VEL;
		end else if (kind == mtep_pkg::KIND_PROGRAM || kind == mtep_pkg::KIND_PRESSURE) begin
			parse_phase = mtep_pkg::PH_DELTA;
		end else begin
			skip_left   = mtep_pkg::VLQ_WIDTH'(1);
			parse_phase = mtep_pkg::PH_SKIP;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic lst, output bit got,
		output mtep_pkg::result_t r);
		logic [mtep_pkg::DELTA_W:0] sum;
		logic                       off;
		got = 1'b0;
		r   = NO_NOTE;
		case (parse_phase)
			mtep_pkg::PH_STATUS: begin
				if (!b[7]) begin
					if (run_status == 0)
						parse_phase = mtep_pkg::PH_DELTA;
					else
						take_first_data(b);
				end else if (b[7:4] != mtep_pkg::KIND_SYSTEM) begin
					run_status  = b;
					parse_phase = mtep_pkg::PH_DATA1;
				end else if (b == mtep_pkg::ST_META) begin
					run_status  = '0;
					parse_phase = mtep_pkg::PH_META_TYPE;
				end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
					run_status  = '0;
					vlq_val     = '0;
					parse_phase = mtep_pkg::PH_SYSEX_LEN;
				end else begin
					run_status  = '0;
					parse_phase = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_DATA1: take_first_data(b);
			mtep_pkg::PH_NOTE_VEL: begin
				off             = (run_status[7:4] == mtep_pkg::KIND_NOTE_OFF);
				r.delta_ticks   = ticks_pending;
				r.note_number   = note_key;
				r.velocity      = off ? '0 : b[6:0];
				r.is_note_off   = off;
				r.channel       = run_status[3:0];
				r.current_tempo = tempo_us;
				got             = 1'b1;
				ticks_pending   = '0;
				parse_phase     = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_SKIP: begin
				if (skip_left != 0)
					skip_left--;
				if (skip_left == 0)
					parse_phase = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_META_TYPE: begin
				meta_type   = b;
				vlq_val     = '0;
				parse_phase = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				vlq_val = vlq_push(vlq_val, b);
				if (!b[7]) begin
					skip_left   = vlq_val;
					vlq_val     = '0;
					parse_phase = (skip_left == 0) ? mtep_pkg::PH_DELTA
						: mtep_pkg::PH_META_DATA;
				end
			end
			mtep_pkg::PH_META_DATA: begin
				// tempo bytes shift in big-endian, only 24 bits survive
				if (meta_type == mtep_pkg::META_TEMPO)
					vlq_val = mtep_pkg::VLQ_WIDTH'({vlq_val[15:0], b});
				if (skip_left != 0)
					skip_left--;
				if (skip_left == 0) begin
					if (meta_type == mtep_pkg::META_TEMPO)
						tempo_us = vlq_val[mtep_pkg::TEMPO_W-1:0];
					vlq_val     = '0;
					parse_phase = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_SYSEX_LEN: begin
				vlq_val = vlq_push(vlq_val, b);
				if (!b[7]) begin
					skip_left   = vlq_val;
					parse_phase = (vlq_val == 0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
					vlq_val     = '0;
				end
			end
			default: begin
				vlq_val = vlq_push(vlq_val, b);
				if (!b[7]) begin
					sum           = {1'b0, ticks_pending}
						+ (mtep_pkg::DELTA_W + 1)'(vlq_val);
					ticks_pending = sum[mtep_pkg::DELTA_W] ? mtep_pkg::DELTA_MAX
						: sum[mtep_pkg::DELTA_W-1:0];
					vlq_val       = '0;
					parse_phase   = mtep_pkg::PH_STATUS;
				end
			end
		endcase
		if (lst)
			clear_parse_state();
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
		input mtep_pkg::result_t want);
		bit                got;
		mtep_pkg::result_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		parse_byte(b, lst, got, r);
		if (got)
			notes_due.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic push_vlq(input logic [31:0] v);
		logic [7:0]  grp[$];
		logic [31:0] rest;
		rest = v;
		grp.push_front({1'b0, rest[6:0]});
		rest = rest >> 7;
		while (rest != 0) begin
			grp.push_front({1'b1, rest[6:0]});
			rest = rest >> 7;
		end
		foreach (grp[i])
			ev_bytes.push_back(grp[i]);
	endtask

	task automatic push_delta();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			push_vlq($urandom_range(0, 127));
		end else if (pick < 85) begin
			push_vlq($urandom_range(128, 16383));
		end else if (pick < 95) begin
			push_vlq($urandom & 32'h0FFFFFFF);
		end else begin
			// too many continuation groups, value clips
			repeat ($urandom_range(4, 6))
				ev_bytes.push_back(8'($urandom_range(128, 255)));
			ev_bytes.push_back(8'($urandom_range(0, 127)));
		end
	endtask

	function automatic logic [7:0] data_word();
		return ($urandom_range(15) == 0) ? 8'($urandom_range(128, 255))
			: 8'($urandom_range(0, 127));
	endfunction

	task automatic send_event();
		int         pick;
		int         n;
		logic [7:0] st;
		logic [7:0] mt;
		bit         end_trk;
		bit         lst;
		ev_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 92)
			push_delta();
		if (pick < 40) begin
			st = {3'b100, 1'($urandom_range(1)), 4'($urandom_range(15))};
			ev_bytes.push_back(st);
			ev_bytes.push_back(data_word());
			ev_bytes.push_back(data_word());
		end else if (pick < 60) begin
			// running status, no status word
			ev_bytes.push_back(data_word());
			ev_bytes.push_back(data_word());
		end else if (pick < 70) begin
			st = {4'($urandom_range(10, 14)), 4'($urandom_range(15))};
			ev_bytes.push_back(st);
			ev_bytes.push_back(data_word());
			if (st[7:4] != mtep_pkg::KIND_PROGRAM && st[7:4] != mtep_pkg::KIND_PRESSURE)
				ev_bytes.push_back(data_word());
		end else if (pick < 80) begin
			mt = $urandom_range(1) ? mtep_pkg::META_TEMPO : 8'($urandom_range(255));
			ev_bytes.push_back(mtep_pkg::ST_META);
			ev_bytes.push_back(mt);
			if ($urandom_range(49) == 0)
				n = $urandom_range(128, 200);
			else if (mt == mtep_pkg::META_TEMPO && $urandom_range(3) != 0)
				n = 3;
			else
				n = $urandom_range(0, 6);
			push_vlq(n);
			repeat (n)
				ev_bytes.push_back(8'($urandom_range(255)));
		end else if (pick < 87) begin
			ev_bytes.push_back($urandom_range(1) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_SYSEX_ESC);
			n = $urandom_range(0, 6);
			push_vlq(n);
			repeat (n)
				ev_bytes.push_back(8'($urandom_range(255)));
		end else if (pick < 92) begin
			do
				st = 8'($urandom_range(8'hF1, 8'hFE));
			while (st == mtep_pkg::ST_SYSEX_ESC);
			ev_bytes.push_back(st);
		end else begin
			repeat ($urandom_range(1, 3))
				ev_bytes.push_back(8'($urandom_range(255)));
		end
		end_trk = ($urandom_range(39) == 0);
		foreach (ev_bytes[i]) begin
			lst = (end_trk && i == ev_bytes.size() - 1) || ($urandom_range(299) == 0);
			send_byte(ev_bytes[i], lst, 1'b0, NO_NOTE);
		end
	endtask

	task automatic cmp_field(input string fld, input int unsigned want, input int unsigned seen);
		if (want != seen) begin
			$error("%s: expected 0x%0h, got 0x%0h", fld, want, seen);
			errs++;
		end
	endtask

	always @(posedge clk) begin : note_mon
		mtep_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (notes_due.size() == 0) begin
				$error("note word with none expected: tdata 0x%0h", m_axis_tdata);
				errs++;
			end else begin
				want = notes_due.pop_front();
				cmp_field("delta_ticks", want.delta_ticks, m_axis_tdata[27:0]);
				cmp_field("note_number", want.note_number, m_axis_tdata[34:28]);
				cmp_field("velocity", want.velocity, m_axis_tdata[41:35]);
				cmp_field("is_note_off", want.is_note_off, m_axis_tuser);
				cmp_field("channel", want.channel, m_axis_tdata[45:42]);
				cmp_field("current_tempo", want.current_tempo, m_axis_tdata[69:46]);
			end
		end
	end

	initial begin
		int k;
		clear_parse_state();
		tempo_us      = mtep_pkg::TEMPO_RESET;
		errs          = 0;
		items_sent    = 0;
		idle_pct      = 0;
		stall_pct     = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		dir_tab = '{
			// data word before any status is dropped
			{8'h00, 1'b0, 1'b0, NO_NOTE},
			{8'h45, 1'b0, 1'b0, NO_NOTE},
			// note-on with zero velocity stays a note-on
			{8'h00, 1'b0, 1'b0, NO_NOTE},
			{8'h90, 1'b0, 1'b0, NO_NOTE},
			{8'h3C, 1'b0, 1'b0, NO_NOTE},
			{8'h00, 1'b0, 1'b1, 28'd0, 7'd60, 7'd0, 1'b0, 4'h0, mtep_pkg::TEMPO_RESET},
			// three-group delta, then running status with bit 7 set on velocity
			{8'h81, 1'b0, 1'b0, NO_NOTE},
			{8'h80, 1'b0, 1'b0, NO_NOTE},
			{8'h00, 1'b0, 1'b0, NO_NOTE},
			{8'h7F, 1'b0, 1'b0, NO_NOTE},
			{8'hC0, 1'b0, 1'b1, 28'd16384, 7'd127, 7'd64, 1'b0, 4'h0,
				mtep_pkg::TEMPO_RESET},
			// two-word tempo meta
			{8'h00, 1'b0, 1'b0, NO_NOTE},
			{mtep_pkg::ST_META, 1'b0, 1'b0, NO_NOTE},
			{mtep_pkg::META_TEMPO, 1'b0, 1'b0, NO_NOTE},
			{8'h02, 1'b0, 1'b0, NO_NOTE},
			{8'hAB, 1'b0, 1'b0, NO_NOTE},
			{8'hCD, 1'b0, 1'b0, NO_NOTE},
			// delta that clips at all ones
			{8'hFF, 1'b0, 1'b0, NO_NOTE},
			{8'hFF, 1'b0, 1'b0, NO_NOTE},
			{8'hFF, 1'b0, 1'b0, NO_NOTE},
			{8'hFF, 1'b0, 1'b0, NO_NOTE},
			{8'h7F, 1'b0, 1'b0, NO_NOTE},
			// system status without data, then note-off closing the track
			{8'hF4, 1'b0, 1'b0, NO_NOTE},
			{8'h00, 1'b0, 1'b0, NO_NOTE},
			{8'h8F, 1'b0, 1'b0, NO_NOTE},
			{8'h00, 1'b0, 1'b0, NO_NOTE},
			{8'hFF, 1'b1, 1'b1, mtep_pkg::DELTA_MAX, 7'd0, 7'd0, 1'b1, 4'hF, 24'h00ABCD}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send_byte(dir_tab[i].b, dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].want);
		for (k = 0; k < 4; k++) begin
			case (k)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 52;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 52;
				end
				default: begin
					idle_pct  = 7;
					stall_pct = 7;
				end
			endcase
			while (items_sent < DIR_ROWS + (k + 1) * PHASE_ITEMS)
				send_event();
		end
		s_axis_tvalid <= 1'b0;
		while (notes_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
